@@ design/md5_stream_digest_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the MD5 stream core.
// ---------------------------------------------------------------------------
`ifndef MD5_STREAM_DIGEST_CORE_MACROS_SVH
`define MD5_STREAM_DIGEST_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5 core: implication check failed");

// Next-cycle implication, disabled while reset is high
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5 core: next-cycle check failed");

`endif

@@ design/md5_pkg.sv @@
// ---------------------------------------------------------------------------
// md5_pkg
// Types, round constants and index functions for the MD5 stream core.
// ---------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned DataBits  = 64;
  localparam int unsigned BlkWords  = 8;
  localparam int unsigned CountBits = 58;

  localparam logic [WordBits-1:0] IvA = 32'h67452301;
  localparam logic [WordBits-1:0] IvB = 32'hefcdab89;
  localparam logic [WordBits-1:0] IvC = 32'h98badcfe;
  localparam logic [WordBits-1:0] IvD = 32'h10325476;

  localparam logic [DataBits-1:0] PadByte = 64'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } md5_state_t;

  // Source of the sixteen message words seen by the rounds
  typedef enum logic [1:0] {
    BLK_DATA,      // all eight buffered words
    BLK_PAD_LEN,   // buffered words, pad byte, length in the last word
    BLK_PAD_ONLY,  // seven buffered words, pad byte in the last word
    BLK_LEN_ONLY   // zeros, length in the last word
  } md5_blk_mode_t;

  typedef struct packed {
    logic [WordBits-1:0] a;
    logic [WordBits-1:0] b;
    logic [WordBits-1:0] c;
    logic [WordBits-1:0] d;
  } md5_abcd_t;

  typedef struct packed {
    md5_blk_mode_t mode;
    logic [2:0]    fill;
    logic [3:0]    g;
  } md5_rd_req_t;

  // Message word index used by a round
  function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
    logic [9:0] r;
    logic [9:0] t;
    r = {4'd0, rnd};
    case (rnd[5:4])
      2'd0:    t = r;
      2'd1:    t = 10'd5 * r + 10'd1;
      2'd2:    t = 10'd3 * r + 10'd5;
      default: t = 10'd7 * r;
    endcase
    return t[3:0];
  endfunction

  // Left rotation amount of a round
  function automatic logic [4:0] md5_shift(input logic [5:0] rnd);
    logic [3:0] sel;
    logic [4:0] s;
    sel = {rnd[5:4], rnd[1:0]};
    case (sel)
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Additive round constant
  function automatic logic [WordBits-1:0] md5_round_k(input logic [5:0] rnd);
    logic [WordBits-1:0] k;
    case (rnd)
      6'd0:    k = 32'd3614090360;
      6'd1:    k = 32'd3905402710;
      6'd2:    k = 32'd606105819;
      6'd3:    k = 32'd3250441966;
      6'd4:    k = 32'd4118548399;
      6'd5:    k = 32'd1200080426;
      6'd6:    k = 32'd2821735955;
      6'd7:    k = 32'd4249261313;
      6'd8:    k = 32'd1770035416;
      6'd9:    k = 32'd2336552879;
      6'd10:   k = 32'd4294925233;
      6'd11:   k = 32'd2304563134;
      6'd12:   k = 32'd1804603682;
      6'd13:   k = 32'd4254626195;
      6'd14:   k = 32'd2792965006;
      6'd15:   k = 32'd1236535329;
      6'd16:   k = 32'd4129170786;
      6'd17:   k = 32'd3225465664;
      6'd18:   k = 32'd643717713;
      6'd19:   k = 32'd3921069994;
      6'd20:   k = 32'd3593408605;
      6'd21:   k = 32'd38016083;
      6'd22:   k = 32'd3634488961;
      6'd23:   k = 32'd3889429448;
      6'd24:   k = 32'd568446438;
      6'd25:   k = 32'd3275163606;
      6'd26:   k = 32'd4107603335;
      6'd27:   k = 32'd1163531501;
      6'd28:   k = 32'd2850285829;
      6'd29:   k = 32'd4243563512;
      6'd30:   k = 32'd1735328473;
      6'd31:   k = 32'd2368359562;
      6'd32:   k = 32'd4294588738;
      6'd33:   k = 32'd2272392833;
      6'd34:   k = 32'd1839030562;
      6'd35:   k = 32'd4259657740;
      6'd36:   k = 32'd2763975236;
      6'd37:   k = 32'd1272893353;
      6'd38:   k = 32'd4139469664;
      6'd39:   k = 32'd3200236656;
      6'd40:   k = 32'd681279174;
      6'd41:   k = 32'd3936430074;
      6'd42:   k = 32'd3572445317;
      6'd43:   k = 32'd76029189;
      6'd44:   k = 32'd3654602809;
      6'd45:   k = 32'd3873151461;
      6'd46:   k = 32'd530742520;
      6'd47:   k = 32'd3299628645;
      6'd48:   k = 32'd4096336452;
      6'd49:   k = 32'd1126891415;
      6'd50:   k = 32'd2878612391;
      6'd51:   k = 32'd4237533241;
      6'd52:   k = 32'd1700485571;
      6'd53:   k = 32'd2399980690;
      6'd54:   k = 32'd4293915773;
      6'd55:   k = 32'd2240044497;
      6'd56:   k = 32'd1873313359;
      6'd57:   k = 32'd4264355552;
      6'd58:   k = 32'd2734768916;
      6'd59:   k = 32'd1309151649;
      6'd60:   k = 32'd4149444226;
      6'd61:   k = 32'd3174756917;
      6'd62:   k = 32'd718787259;
      default: k = 32'd3951481745;
    endcase
    return k;
  endfunction

endpackage

@@ design/md5_stream_digest_core.sv @@
// ---------------------------------------------------------------------------
// md5_stream_digest_core
// Streaming MD5 engine over 64-bit little-endian message words.
// ---------------------------------------------------------------------------
// A data request (tuser 0) is written into the open block; the eighth word of a
// block starts a compression that runs one round per cycle through the shared
// round unit, 64 rounds and then a fold of the result into the chaining value,
// and the input is not ready from that word until the fold is done. A finish
// request (tuser 1) closes the message with pad byte and bit length and
// compresses once, or twice when seven words are held, then places the digest
// in the output register once it is free and restarts from the initial value.
// The output register holds its digest until taken while new data is accepted;
// a further digest waits in the sequencer until that register is free.
// ---------------------------------------------------------------------------
module md5_stream_digest_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [63:0] data_word
  input  logic         s_tuser,   // [0] req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // [63:0] digest_low, [127:64] digest_high
);
  import md5_pkg::*;

  md5_state_t          state;
  md5_state_t          state_next;
  md5_blk_mode_t       mode;
  md5_abcd_t           work;
  md5_abcd_t           work_next;
  md5_abcd_t           chain;
  md5_abcd_t           chain_sum;
  md5_rd_req_t         rd_req;
  logic [5:0]          rnd;
  logic [2:0]          fill;
  logic [CountBits-1:0] blocks;
  logic                fin;
  logic [DataBits-1:0] len_bits;
  logic [WordBits-1:0] msg;
  logic                acc;
  logic                acc_data;
  logic                acc_fin;
  logic                out_free;
  logic                load_out;

  assign acc      = s_tvalid && s_tready;
  assign acc_data = acc && !s_tuser;
  assign acc_fin  = acc && s_tuser;
  assign out_free = !m_tvalid || m_tready;

  // Bit count: blocks times 512 plus words times 64, taken modulo 2^64
  assign len_bits = {blocks[54:0], fill, 6'd0};

  assign chain_sum.a = chain.a + work.a;
  assign chain_sum.b = chain.b + work.b;
  assign chain_sum.c = chain.c + work.c;
  assign chain_sum.d = chain.d + work.d;

  assign rd_req.mode = mode;
  assign rd_req.fill = fill;
  assign rd_req.g    = md5_msg_index(rnd);

  md5_word_store u_store (
    .clk      (clk),
    .wr_en    (acc_data),
    .wr_idx   (fill),
    .wr_data  (s_tdata),
    .rd_req   (rd_req),
    .len_bits (len_bits),
    .msg      (msg)
  );

  md5_round u_round (
    .rnd (rnd),
    .msg (msg),
    .cur (work),
    .nxt (work_next)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (acc_fin || (acc_data && fill == 3'd7)) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (mode == BLK_PAD_ONLY) state_next = ST_ROUND;
        else if (fin)             state_next = ST_DONE;
        else                      state_next = ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Message and compression control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      blocks <= '0;
      fin    <= 1'b0;
      mode   <= BLK_DATA;
      rnd    <= '0;
      chain  <= {IvA, IvB, IvC, IvD};
    end else begin
      case (state)
        ST_IDLE: begin
          rnd <= '0;
          if (acc_data) begin
            fill <= fill + 3'd1;
            mode <= BLK_DATA;
            fin  <= 1'b0;
          end else if (acc_fin) begin
            mode <= (fill == 3'd7) ? BLK_PAD_ONLY : BLK_PAD_LEN;
            fin  <= 1'b1;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
        end
        ST_ADD: begin
          chain <= chain_sum;
          rnd   <= '0;
          if (mode == BLK_PAD_ONLY) begin
            mode <= BLK_LEN_ONLY;
          end else if (!fin) begin
            blocks <= blocks + {{(CountBits-1){1'b0}}, 1'b1};
          end
        end
        ST_DONE: begin
          // Restart the message once the digest is loaded into the output register
          if (load_out) begin
            chain  <= {IvA, IvB, IvC, IvD};
            fill   <= '0;
            blocks <= '0;
            fin    <= 1'b0;
          end
        end
        default: begin
          rnd <= '0;
        end
      endcase
    end
  end

  // Working registers: seed from the chain, advance one round per cycle
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE:  work <= chain;
      ST_ROUND: work <= work_next;
      ST_ADD:   work <= chain_sum;
      default:  work <= work;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {chain.d, chain.c, chain.b, chain.a};
    end
  end

endmodule

@@ design/md5_round.sv @@
// ---------------------------------------------------------------------------
// md5_round
// One MD5 round: boolean function, four-term sum, rotation and state shift.
// ---------------------------------------------------------------------------
module md5_round (
  input  logic [5:0]                 rnd,
  input  logic [md5_pkg::WordBits-1:0] msg,
  input  md5_pkg::md5_abcd_t         cur,
  output md5_pkg::md5_abcd_t         nxt
);
  import md5_pkg::*;

  logic [WordBits-1:0]   f;
  logic [WordBits-1:0]   sum;
  logic [2*WordBits-1:0] dbl;

  // Select the boolean function of the current quarter
  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.d & cur.b) | (~cur.d & cur.c);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
  end

  // Add, rotate left through a doubled word, then rotate the registers
  assign sum   = cur.a + f + md5_round_k(rnd) + msg;
  assign dbl   = {sum, sum} << md5_shift(rnd);
  assign nxt.a = cur.d;
  assign nxt.b = cur.b + dbl[2*WordBits-1:WordBits];
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule

@@ design/md5_word_store.sv @@
// ---------------------------------------------------------------------------
// md5_word_store
// Holds the open block and supplies the message word of each round,
// inserting the pad byte and the bit length for the closing blocks.
// ---------------------------------------------------------------------------
module md5_word_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [2:0]                   wr_idx,
  input  logic [md5_pkg::DataBits-1:0] wr_data,
  input  md5_pkg::md5_rd_req_t         rd_req,
  input  logic [md5_pkg::DataBits-1:0] len_bits,
  output logic [md5_pkg::WordBits-1:0] msg
);
  import md5_pkg::*;

  logic [DataBits-1:0] blk_buf [BlkWords];
  logic [2:0]          idx;
  logic [DataBits-1:0] word;

  // Store an incoming data word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_buf[wr_idx] <= wr_data;
    end
  end

  assign idx = rd_req.g[3:1];

  // Build the 64-bit block word for the selected source
  always_comb begin
    case (rd_req.mode)
      BLK_DATA: begin
        word = blk_buf[idx];
      end
      BLK_PAD_LEN: begin
        if (idx == 3'd7)              word = len_bits;
        else if (idx < rd_req.fill)   word = blk_buf[idx];
        else if (idx == rd_req.fill)  word = PadByte;
        else                          word = '0;
      end
      BLK_PAD_ONLY: begin
        if (idx == 3'd7) word = PadByte;
        else             word = blk_buf[idx];
      end
      default: begin
        if (idx == 3'd7) word = len_bits;
        else             word = '0;
      end
    endcase
  end

  assign msg = rd_req.g[0] ? word[DataBits-1:WordBits] : word[WordBits-1:0];

endmodule

@@ design/md5_core_checker.sv @@
// ---------------------------------------------------------------------------
// md5_core_checker
// Port-level checks of the MD5 stream core, bound to its top level.
// ---------------------------------------------------------------------------
`include "md5_stream_digest_core_macros.svh"

module md5_core_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [63:0]  s_tdata,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  logic fin_req;
  logic data_req;

  assign fin_req  = s_tvalid && s_tready && s_tuser;
  assign data_req = s_tvalid && s_tready && !s_tuser && (s_tdata == s_tdata);

  // Hold a stalled digest
  `MD5_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A finish request occupies the engine
  `MD5_ASSERT_NEXT(a_fin_busy, clk, rst, fin_req, !s_tready)

  // A new digest only follows a busy period
  `MD5_ASSERT_IMPL(a_out_after_busy, clk, rst, $rose(m_tvalid), !$past(s_tready))

  // A data request never produces a digest at once
  `MD5_ASSERT_NEXT(a_data_no_out, clk, rst, data_req, !$rose(m_tvalid))

endmodule

bind md5_stream_digest_core md5_core_checker u_md5_core_checker (.*);
